/* rtl/jddm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types, widths and the arctangent table of the drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

	// joystick and speed field widths
	localparam int JOY_W   = 8;
	localparam int SPEED_W = 9;

	// cordic vector datapath: sample scaled up by 2^PRE_SHIFT, room for the gain
	localparam int PRE_SHIFT = 24;
	localparam int XY_W      = 34;

	// integer square root: sum of squares stays below 2^15, eight root digits
	localparam int N_W        = 15;
	localparam int R_W        = 16;
	localparam int SQRT_STEPS = 8;

	// arctangent table length
	localparam int ATAN_LEN = 24;

	// atan(2^-i) as a fraction of a turn, 32 fraction bits
	localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// per-sample sideband that travels with the vector
	typedef struct packed {
		logic       on_axis;    // angle is exact, taken from quarter
		logic [1:0] quarter;    // quarter-turn count for axis samples
		logic       half_turn;  // vector was turned by a half turn
		logic       neg;        // y below zero, magnitude negated
	} side_t;

	// rounded angle step of stage idx at ab angle bits
	function automatic logic [31:0] atan_step(input int idx, input int ab);
		logic [32:0] t;
		t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - ab));
		return t[31:0] >> (32 - ab);
	endfunction

endpackage
`default_nettype wire

/* rtl/jddm_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jddm_prep
// Clamps the sample, forms the sum of squares and the pre-rotated vector.
// ----------------------------------------------------------------------------
module jddm_prep import jddm_pkg::*; #(
	parameter int JOY_LIMIT = 100
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    valid_i,
	output      logic                    ready_o,
	input  wire logic signed [JOY_W-1:0] joy_x,
	input  wire logic signed [JOY_W-1:0] joy_y,
	output      logic                    valid_o,
	input  wire logic                    ready_i,
	output      logic signed [XY_W-1:0]  x_o,
	output      logic signed [XY_W-1:0]  y_o,
	output      logic        [N_W-1:0]   n_o,
	output      side_t                   side_o
);

	localparam logic signed [JOY_W-1:0] LIM = JOY_W'(JOY_LIMIT);

	logic signed [JOY_W-1:0]   xc, yc, xr, yr;
	logic signed [2*JOY_W-1:0] sqx, sqy;
	side_t                     side_d;
	logic                      valid_s1;
	logic signed [XY_W-1:0]    x_s1, y_s1;
	logic        [N_W-1:0]     n_s1;
	side_t                     side_s1;

	// clamp to the joystick limit
	always_comb begin
		xc = joy_x;
		if (joy_x > LIM) xc = LIM;
		if (joy_x < -LIM) xc = -LIM;
		yc = joy_y;
		if (joy_y > LIM) yc = LIM;
		if (joy_y < -LIM) yc = -LIM;
	end

	// squares for the root
	assign sqx = xc * xc;
	assign sqy = yc * yc;

	// axis detection and half-turn pre-rotation
	always_comb begin
		side_d.neg       = yc[JOY_W-1];
		side_d.half_turn = xc[JOY_W-1];
		side_d.on_axis   = (xc == '0) || (yc == '0);
		if (yc == '0) side_d.quarter = xc[JOY_W-1] ? 2'd2 : 2'd0;
		else side_d.quarter = yc[JOY_W-1] ? 2'd3 : 2'd1;
		xr = xc[JOY_W-1] ? -xc : xc;
		yr = xc[JOY_W-1] ? -yc : yc;
	end

	assign ready_o = !valid_s1 || ready_i;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (ready_o) valid_s1 <= valid_i;
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			x_s1    <= {{(XY_W-JOY_W){xr[JOY_W-1]}}, xr} <<< PRE_SHIFT;
			y_s1    <= {{(XY_W-JOY_W){yr[JOY_W-1]}}, yr} <<< PRE_SHIFT;
			n_s1    <= N_W'(sqx) + N_W'(sqy);
			side_s1 <= side_d;
		end
	end

	assign valid_o = valid_s1;
	assign x_o     = x_s1;
	assign y_o     = y_s1;
	assign n_o     = n_s1;
	assign side_o  = side_s1;

endmodule
`default_nettype wire

/* rtl/jddm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jddm_cell
// One cordic vectoring rotation plus, in the first SQRT_STEPS cells, one square-root digit, registered.
// ----------------------------------------------------------------------------
module jddm_cell import jddm_pkg::*; #(
	parameter int IDX         = 0,
	parameter int ANGLE_BITS  = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_i,
	output      logic                        ready_o,
	input  wire logic signed [XY_W-1:0]      x_i,
	input  wire logic signed [XY_W-1:0]      y_i,
	input  wire logic signed [ANGLE_BITS:0]  z_i,
	input  wire logic        [N_W-1:0]       n_i,
	input  wire logic        [R_W-1:0]       root_i,
	input  wire side_t                       side_i,
	output      logic                        valid_o,
	input  wire logic                        ready_i,
	output      logic signed [XY_W-1:0]      x_o,
	output      logic signed [XY_W-1:0]      y_o,
	output      logic signed [ANGLE_BITS:0]  z_o,
	output      logic        [N_W-1:0]       n_o,
	output      logic        [R_W-1:0]       root_o,
	output      side_t                       side_o
);

	localparam int ZW = ANGLE_BITS + 1;
	localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(IDX, ANGLE_BITS));

	logic signed [XY_W-1:0] x_d, y_d;
	logic signed [ZW-1:0]   z_d;
	logic        [N_W-1:0]  n_d;
	logic        [R_W-1:0]  root_d;
	logic                   valid_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic        [N_W-1:0]  n_q;
	logic        [R_W-1:0]  root_q;
	side_t                  side_q;

	// rotate toward the x axis
	always_comb begin
		if (y_i > 0) begin
			x_d = x_i + (y_i >>> IDX);
			y_d = y_i - (x_i >>> IDX);
			z_d = z_i + STEP;
		end else begin
			x_d = x_i - (y_i >>> IDX);
			y_d = y_i + (x_i >>> IDX);
			z_d = z_i - STEP;
		end
	end

	// one root digit, or pass through once all digits are done
	generate
		if (IDX < SQRT_STEPS) begin : g_root
			localparam logic [R_W:0] SBIT = (R_W+1)'(1) << (2 * (SQRT_STEPS - 1 - IDX));
			logic [R_W:0] trial;
			always_comb begin
				trial = {1'b0, root_i} + SBIT;
				if ({2'b00, n_i} >= trial) begin
					n_d    = N_W'({2'b00, n_i} - trial);
					root_d = R_W'({1'b0, root_i >> 1} + SBIT);
				end else begin
					n_d    = n_i;
					root_d = root_i >> 1;
				end
			end
		end else begin : g_pass
			assign n_d    = n_i;
			assign root_d = root_i;
		end
	endgenerate

	assign ready_o = !valid_q || ready_i;

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (ready_o) valid_q <= valid_i;
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			x_q    <= x_d;
			y_q    <= y_d;
			z_q    <= z_d;
			n_q    <= n_d;
			root_q <= root_d;
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign x_o     = x_q;
	assign y_o     = y_q;
	assign z_o     = z_q;
	assign n_o     = n_q;
	assign root_o  = root_q;
	assign side_o  = side_q;

endmodule
`default_nettype wire

/* rtl/jddm_mix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jddm_mix
// Angle to left/right factors, scaling of the signed magnitude, output register.
// ----------------------------------------------------------------------------
module jddm_mix import jddm_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_i,
	output      logic                       ready_o,
	input  wire logic signed [ANGLE_BITS:0] z_i,
	input  wire logic        [R_W-1:0]      root_i,
	input  wire side_t                      side_i,
	output      logic                       valid_o,
	input  wire logic                       ready_i,
	output      logic signed [SPEED_W-1:0]  left_o,
	output      logic signed [SPEED_W-1:0]  right_o
);

	localparam int FW    = ANGLE_BITS + 1;
	localparam int PW    = SPEED_W + FW;
	localparam int QSH   = ANGLE_BITS - 2;
	localparam logic [ANGLE_BITS-1:0] Q      = ANGLE_BITS'(1) << QSH;
	localparam logic [ANGLE_BITS-1:0] HALF   = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam logic [ANGLE_BITS:0]   Q3     = (ANGLE_BITS+1)'(3) << QSH;
	localparam logic signed [FW-1:0]  Q_F    = FW'(1) << QSH;
	localparam logic signed [FW-1:0]  TWO_Q  = FW'(1) << (QSH + 1);
	localparam logic signed [PW-1:0]  BIAS   = PW'((1 << QSH) - 1);

	logic [ANGLE_BITS-1:0]       ang;
	logic signed [FW-1:0]        lf_d, rf_d, ae;
	logic signed [SPEED_W-1:0]   m_d;
	logic signed [PW-1:0]        pl_b, pr_b;
	logic signed [PW-1:0]        pl_sh, pr_sh;
	logic                        ready_s1, ready_s2, ready_s3;
	logic                        valid_s1, valid_s2, valid_s3;
	logic signed [FW-1:0]        lf_s1, rf_s1;
	logic signed [SPEED_W-1:0]   m_s1;
	logic signed [PW-1:0]        pl_s2, pr_s2;
	logic signed [SPEED_W-1:0]   left_s3, right_s3;

	// final angle, factors and signed magnitude
	always_comb begin
		if (side_i.on_axis) ang = ANGLE_BITS'(side_i.quarter) << QSH;
		else ang = ANGLE_BITS'(z_i) + (side_i.half_turn ? HALF : '0);
		ae = $signed({1'b0, ang});
		if (ang > Q && {1'b0, ang} < Q3) lf_d = TWO_Q - ae;
		else lf_d = Q_F;
		if (ang < Q) rf_d = ae;
		else if ({1'b0, ang} > Q3) rf_d = $signed({1'b1, ang});
		else rf_d = Q_F;
		m_d = side_i.neg ? -$signed(root_i[SPEED_W-1:0]) : $signed(root_i[SPEED_W-1:0]);
	end

	// truncating scale by one quarter turn
	always_comb begin
		pl_b  = pl_s2 + (pl_s2[PW-1] ? BIAS : '0);
		pr_b  = pr_s2 + (pr_s2[PW-1] ? BIAS : '0);
		pl_sh = pl_b >>> QSH;
		pr_sh = pr_b >>> QSH;
	end

	assign ready_s3 = !valid_s3 || ready_i;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign ready_o  = ready_s1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= valid_i;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (ready_s1 && valid_i) begin
			lf_s1 <= lf_d;
			rf_s1 <= rf_d;
			m_s1  <= m_d;
		end
		if (ready_s2 && valid_s1) begin
			pl_s2 <= m_s1 * lf_s1;
			pr_s2 <= m_s1 * rf_s1;
		end
		if (ready_s3 && valid_s2) begin
			left_s3  <= pl_sh[SPEED_W-1:0];
			right_s3 <= pr_sh[SPEED_W-1:0];
		end
	end

	assign valid_o = valid_s3;
	assign left_o  = left_s3;
	assign right_o = right_s3;

endmodule
`default_nettype wire

/* rtl/joystick_differential_drive_mixer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Arcade-drive mixing of one joystick sample into left and right motor speeds.
//
//   channel  valid      ready      payload
//   input    in_valid   in_ready   joy_x, joy_y
//   output   out_valid  out_ready  left_speed, right_speed
//
// One sample per clock sustained while out_ready stays high; the path runs
// through the prep register, the row of cordic cells (one rotation per cell,
// one root digit in each of the first SQRT_STEPS) and the three mixing stages.
// Reset clears only the stage valid flags; no item is in flight after it.
// Each stage holds while its successor is full and stalled, so bubbles close
// up and in_ready stays high until every stage is occupied.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer import jddm_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16,
	parameter int JOY_LIMIT     = 100
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output      logic                      in_ready,
	input  wire logic signed [JOY_W-1:0]   joy_x,
	input  wire logic signed [JOY_W-1:0]   joy_y,
	output      logic                      out_valid,
	input  wire logic                      out_ready,
	output      logic signed [SPEED_W-1:0] left_speed,
	output      logic signed [SPEED_W-1:0] right_speed
);

	logic                       c_valid [CORDIC_STAGES+1];
	logic                       c_ready [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]     c_x     [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]     c_y     [CORDIC_STAGES+1];
	logic signed [ANGLE_BITS:0] c_z     [CORDIC_STAGES+1];
	logic        [N_W-1:0]      c_n     [CORDIC_STAGES+1];
	logic        [R_W-1:0]      c_root  [CORDIC_STAGES+1];
	side_t                      c_side  [CORDIC_STAGES+1];

	// clamp, squares and pre-rotation
	jddm_prep #(
		.JOY_LIMIT(JOY_LIMIT)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (in_valid),
		.ready_o (in_ready),
		.joy_x   (joy_x),
		.joy_y   (joy_y),
		.valid_o (c_valid[0]),
		.ready_i (c_ready[0]),
		.x_o     (c_x[0]),
		.y_o     (c_y[0]),
		.n_o     (c_n[0]),
		.side_o  (c_side[0])
	);

	// angle accumulator and root start from zero
	assign c_z[0]    = '0;
	assign c_root[0] = '0;

	// row of cordic / root cells
	generate
		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
			jddm_cell #(
				.IDX        (i),
				.ANGLE_BITS (ANGLE_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.valid_i (c_valid[i]),
				.ready_o (c_ready[i]),
				.x_i     (c_x[i]),
				.y_i     (c_y[i]),
				.z_i     (c_z[i]),
				.n_i     (c_n[i]),
				.root_i  (c_root[i]),
				.side_i  (c_side[i]),
				.valid_o (c_valid[i+1]),
				.ready_i (c_ready[i+1]),
				.x_o     (c_x[i+1]),
				.y_o     (c_y[i+1]),
				.z_o     (c_z[i+1]),
				.n_o     (c_n[i+1]),
				.root_o  (c_root[i+1]),
				.side_o  (c_side[i+1])
			);
		end
	endgenerate

	// factors, scaling and output register
	jddm_mix #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (c_valid[CORDIC_STAGES]),
		.ready_o (c_ready[CORDIC_STAGES]),
		.z_i     (c_z[CORDIC_STAGES]),
		.root_i  (c_root[CORDIC_STAGES]),
		.side_i  (c_side[CORDIC_STAGES]),
		.valid_o (out_valid),
		.ready_i (out_ready),
		.left_o  (left_speed),
		.right_o (right_speed)
	);

endmodule
`default_nettype wire
